[design/mwe_pkg.sv]
// Shared types and constants for the microwire EEPROM master.
// Holds the command codes, the frame patterns, the phase enum and the tick/result structs.
// No dependencies.
package mwe_pkg;

  localparam int unsigned OpW       = 3;
  localparam int unsigned AddrBits  = 6;
  localparam int unsigned DataW     = 16;
  localparam int unsigned FrameBits = 3 + AddrBits;
  localparam int unsigned FrameIdxW = 4;

  // Command codes on the op field.
  localparam logic [OpW-1:0] OpNone  = 3'd0;
  localparam logic [OpW-1:0] OpRead  = 3'd1;
  localparam logic [OpW-1:0] OpWrite = 3'd2;
  localparam logic [OpW-1:0] OpEwen  = 3'd3;
  localparam logic [OpW-1:0] OpEwds  = 3'd4;
  localparam logic [OpW-1:0] OpEral  = 3'd5;

  // Command frames: start bit, two opcode bits, address bits.
  localparam logic [FrameBits-1:0] FrameStart = 9'h100;
  localparam logic [FrameBits-1:0] FrameRead  = FrameStart | 9'h080;
  localparam logic [FrameBits-1:0] FrameWrite = FrameStart | 9'h040;
  localparam logic [FrameBits-1:0] FrameEwen  = FrameStart | 9'h030;
  localparam logic [FrameBits-1:0] FrameEwds  = FrameStart;
  localparam logic [FrameBits-1:0] FrameEral  = FrameStart | 9'h020;

  typedef enum logic [2:0] {
    PhIdle,
    PhSel,
    PhFrame,
    PhRdata,
    PhWdata,
    PhGap,
    PhPoll,
    PhEnd
  } phase_e;

  typedef struct packed {
    logic [OpW-1:0]      op;
    logic [AddrBits-1:0] address;
    logic [DataW-1:0]    write_data;
    logic                data_out_pin;
  } tick_t;

  typedef struct packed {
    logic             chip_select;
    logic             serial_clock;
    logic             serial_data_in;
    logic             busy_res;
    logic             read_valid;
    logic [DataW-1:0] read_word;
    logic             checksum_valid;
    logic             checksum_ok;
  } res_t;

endpackage

[design/mwe_in_if.sv]
// Input tick channel of the microwire EEPROM master: valid/ready plus the tick fields.
// Depends on mwe_pkg.
interface mwe_in_if import mwe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OpW-1:0]      op;
  logic [AddrBits-1:0] address;
  logic [DataW-1:0]    write_data;
  logic                data_out_pin;

  modport source (output valid, op, address, write_data, data_out_pin, input ready);
  modport sink (input valid, op, address, write_data, data_out_pin, output ready);
endinterface

[design/mwe_out_if.sv]
// Result channel of the microwire EEPROM master: valid/ready plus pin levels and status.
// Depends on mwe_pkg.
interface mwe_out_if import mwe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             chip_select;
  logic             serial_clock;
  logic             serial_data_in;
  logic             busy_res;
  logic             read_valid;
  logic [DataW-1:0] read_word;
  logic             checksum_valid;
  logic             checksum_ok;

  modport source (output valid, chip_select, serial_clock, serial_data_in, busy_res,
                  read_valid, read_word, checksum_valid, checksum_ok, input ready);
  modport sink (input valid, chip_select, serial_clock, serial_data_in, busy_res,
                read_valid, read_word, checksum_valid, checksum_ok, output ready);
endinterface

[design/mwe_seq.sv]
// Pin sequencer of the microwire EEPROM master: phase machine, shifters and checksum.
// Advances one tick per step and gives that tick's pins and status combinationally.
// Depends on mwe_pkg.
module mwe_seq import mwe_pkg::*; #(
  parameter int unsigned WORD_BITS  = 16,
  parameter int unsigned WORD_COUNT = 64
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  tick_t tick_i,
  output res_t  res_o
);

  localparam int unsigned IdxW = $clog2(WORD_BITS);

  phase_e                 phase_q, phase_d;
  logic [4:0]             bit_idx_q, bit_idx_d;
  logic [1:0]             sub_q, sub_d;
  logic [FrameBits-1:0]   cmd_q, cmd_d;
  logic [WORD_BITS-1:0]   data_q, data_d;
  logic [OpW-1:0]         pend_q, pend_d;
  logic [WORD_BITS-1:0]   sum_q, sum_d;

  logic [4:0]             idx_inc;
  logic [FrameIdxW-1:0]   frame_sel;
  logic [IdxW-1:0]        wsel;
  logic [WORD_BITS-1:0]   word_in;
  logic [AddrBits-1:0]    rd_addr;
  logic                   op_valid;

  assign idx_inc   = bit_idx_q + 5'd1;
  assign frame_sel = FrameIdxW'(FrameBits - 1) - bit_idx_q[FrameIdxW-1:0];
  assign wsel      = IdxW'(WORD_BITS - 1) - bit_idx_q[IdxW-1:0];
  assign word_in   = {data_q[WORD_BITS-2:0], tick_i.data_out_pin};
  assign rd_addr   = cmd_q[AddrBits-1:0];
  assign op_valid  = (tick_i.op >= OpRead) && (tick_i.op <= OpEral);

  always_comb begin
    phase_d   = phase_q;
    bit_idx_d = bit_idx_q;
    sub_d     = sub_q;
    cmd_d     = cmd_q;
    data_d    = data_q;
    pend_d    = pend_q;
    sum_d     = sum_q;
    res_o     = '0;
    res_o.busy_res = 1'b1;

    case (phase_q)
      PhIdle: begin
        if (op_valid) begin
          pend_d = tick_i.op;
          case (tick_i.op)
            OpRead:  cmd_d = FrameRead | FrameBits'(tick_i.address);
            OpWrite: cmd_d = FrameWrite | FrameBits'(tick_i.address);
            OpEwen:  cmd_d = FrameEwen;
            OpEwds:  cmd_d = FrameEwds;
            default: cmd_d = FrameEral;
          endcase
          data_d    = (tick_i.op == OpWrite) ? tick_i.write_data[WORD_BITS-1:0] : '0;
          bit_idx_d = '0;
          sub_d     = '0;
          phase_d   = PhSel;
        end else begin
          res_o.busy_res = 1'b0;
        end
      end
      PhSel: begin
        res_o.chip_select = 1'b1;
        bit_idx_d = '0;
        sub_d     = '0;
        phase_d   = PhFrame;
      end
      PhFrame: begin
        res_o.chip_select    = 1'b1;
        res_o.serial_clock   = (sub_q == 2'd1);
        res_o.serial_data_in = (bit_idx_q < 5'(FrameBits)) ? cmd_q[frame_sel] : 1'b0;
        if (sub_q[1]) begin
          sub_d     = '0;
          bit_idx_d = idx_inc;
          if (idx_inc >= 5'(FrameBits)) begin
            bit_idx_d = '0;
            case (pend_q)
              OpRead: begin
                data_d  = '0;
                phase_d = PhRdata;
              end
              OpWrite: phase_d = PhWdata;
              OpEral:  phase_d = PhGap;
              default: phase_d = PhEnd;
            endcase
          end
        end else begin
          sub_d = sub_q + 2'd1;
        end
      end
      PhRdata: begin
        res_o.chip_select = 1'b1;
        if (sub_q == 2'd0) begin
          // The pin seen now belongs to the clock pulse of the previous bit.
          if (bit_idx_q != 5'd0) begin
            data_d = word_in;
          end
          sub_d = 2'd1;
        end else begin
          res_o.serial_clock = 1'b1;
          sub_d     = '0;
          bit_idx_d = idx_inc;
          if (idx_inc >= 5'(WORD_BITS)) begin
            phase_d = PhEnd;
          end
        end
      end
      PhWdata: begin
        res_o.chip_select    = 1'b1;
        res_o.serial_clock   = (sub_q == 2'd1);
        res_o.serial_data_in = (bit_idx_q < 5'(WORD_BITS)) ? data_q[wsel] : 1'b0;
        if (sub_q[1]) begin
          sub_d     = '0;
          bit_idx_d = idx_inc;
          if (idx_inc >= 5'(WORD_BITS)) begin
            bit_idx_d = '0;
            phase_d   = PhGap;
          end
        end else begin
          sub_d = sub_q + 2'd1;
        end
      end
      PhGap: begin
        sub_d   = '0;
        phase_d = PhPoll;
      end
      PhPoll: begin
        // The first selected tick only raises chip select; ready is sampled after it.
        if ((sub_q != 2'd0) && tick_i.data_out_pin) begin
          sub_d   = '0;
          phase_d = PhIdle;
        end else begin
          res_o.chip_select = 1'b1;
          sub_d = 2'd1;
        end
      end
      PhEnd: begin
        if (pend_q == OpRead) begin
          data_d           = word_in;
          res_o.read_valid = 1'b1;
          res_o.read_word  = DataW'(word_in);
          if (rd_addr == '0) begin
            sum_d = word_in;
          end else if ({1'b0, rd_addr} < 7'(WORD_COUNT - 1)) begin
            sum_d = sum_q + word_in;
          end else if ({1'b0, rd_addr} == 7'(WORD_COUNT - 1)) begin
            res_o.checksum_valid = 1'b1;
            res_o.checksum_ok    = (word_in == ~sum_q);
          end
        end
        bit_idx_d = '0;
        sub_d     = '0;
        phase_d   = PhIdle;
      end
      default: begin
        phase_d   = PhIdle;
        bit_idx_d = '0;
        sub_d     = '0;
        cmd_d     = '0;
        data_d    = '0;
        pend_d    = '0;
        sum_d     = '0;
        res_o.busy_res = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      bit_idx_q <= '0;
      sub_q     <= '0;
      cmd_q     <= '0;
      data_q    <= '0;
      pend_q    <= '0;
      sum_q     <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      bit_idx_q <= bit_idx_d;
      sub_q     <= sub_d;
      cmd_q     <= cmd_d;
      data_q    <= data_d;
      pend_q    <= pend_d;
      sum_q     <= sum_d;
    end
  end

  a_start_selects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (phase_q == PhIdle) && op_valid |=> phase_q == PhSel)
    else $error("accepted command did not move to the select tick");

  a_read_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.read_valid |-> (phase_q == PhEnd) && (pend_q == OpRead))
    else $error("read word reported outside the end of a read");

  a_check_is_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.checksum_valid |-> res_o.read_valid && (rd_addr == AddrBits'(WORD_COUNT - 1)))
    else $error("checksum reported without a read of the checksum word");

  a_frame_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhFrame) |-> (bit_idx_q < 5'(FrameBits)) && (sub_q != 2'd3))
    else $error("frame bit counter out of range");

endmodule

[design/microwire_eeprom_master.sv]
// Top level of the microwire EEPROM master: tick handshake and registered result stage.
// Depends on mwe_pkg, mwe_in_if, mwe_out_if and mwe_seq.
//
//   channel   dir  modport  payload
//   in_i      in   sink     op, address, write_data, data_out_pin
//   out_o     out  source   chip_select, serial_clock, serial_data_in, busy_res,
//                           read_valid, read_word, checksum_valid, checksum_ok
//
// The sequencer state and the result register load together on the edge that accepts
// a tick, and the result is offered on the next cycle.
// A new tick is taken every cycle as long as the result register is empty or being read.
// A stalled result holds the sequencer; no tick is lost or repeated.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle with a zero checksum
// and empties the result register.
module microwire_eeprom_master import mwe_pkg::*; #(
  parameter int unsigned WORD_BITS  = 16,
  parameter int unsigned WORD_COUNT = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mwe_in_if.sink    in_i,
  mwe_out_if.source out_o
);

  logic  out_valid_q;
  res_t  res_q;
  res_t  res_d;
  tick_t tick;
  logic  in_accept;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  assign tick.op           = in_i.op;
  assign tick.address      = in_i.address;
  assign tick.write_data   = in_i.write_data;
  assign tick.data_out_pin = in_i.data_out_pin;

  mwe_seq #(
    .WORD_BITS  (WORD_BITS),
    .WORD_COUNT (WORD_COUNT)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_accept),
    .tick_i (tick),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.chip_select    = res_q.chip_select;
  assign out_o.serial_clock   = res_q.serial_clock;
  assign out_o.serial_data_in = res_q.serial_data_in;
  assign out_o.busy_res       = res_q.busy_res;
  assign out_o.read_valid     = res_q.read_valid;
  assign out_o.read_word      = res_q.read_word;
  assign out_o.checksum_valid = res_q.checksum_valid;
  assign out_o.checksum_ok    = res_q.checksum_ok;

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_q)
    else $error("accepted tick left no result");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled while the result stage is empty");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !in_accept)
    else $error("tick taken while a result is still waiting");

endmodule
